// ----- rtl/dsrgb_pkg.sv -----
// Shared types, widths and register codes for the display stretch and RGB balance block.
// No dependencies; every other file imports this package.
package dsrgb_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_BITS   = 16;
  localparam int GAIN_FRAC   = 14;
  localparam int MIN_BITS    = 16;
  localparam int SCALE_BITS  = 25;
  localparam int LEVEL_BITS  = 8;
  localparam int CFG_BITS    = 25;
  localparam int INDEX_BITS  = 3;

  localparam int PROD_FRAC   = 30;
  localparam int DIFF_EXP    = 38;
  localparam int SAT_BITS    = DIFF_EXP + 2;
  localparam int LO_BITS     = 20;
  localparam int HI_BITS     = SAT_BITS - LO_BITS;
  localparam int BAL_BITS    = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int MINQ_BITS   = MIN_BITS + GAIN_FRAC;
  localparam int DIFF_BITS   = ((BAL_BITS > MINQ_BITS) ? BAL_BITS : MINQ_BITS) + 1;
  localparam int WIDE_BITS   = (DIFF_BITS > SAT_BITS) ? DIFF_BITS : SAT_BITS;
  localparam int PL_BITS     = LO_BITS + 1 + SCALE_BITS;
  localparam int PH_BITS     = HI_BITS + SCALE_BITS;
  localparam int PROD_BITS   = SAT_BITS + SCALE_BITS;

  localparam logic [GAIN_BITS-1:0]  GAIN_UNITY  = GAIN_BITS'(1 << GAIN_FRAC);
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX   = '1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MIN   = '0;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_RGB_MODE      = 3'd0,
    REG_FRAME_SELECT  = 3'd1,
    REG_DISPLAY_MIN   = 3'd2,
    REG_STRETCH_SCALE = 3'd3,
    REG_GAIN_RED      = 3'd4,
    REG_GAIN_GREEN    = 3'd5,
    REG_GAIN_BLUE     = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    SEL_RED   = 2'd0,
    SEL_GREEN = 2'd1,
    SEL_BLUE  = 2'd2,
    SEL_ALL   = 2'd3
  } frame_sel_t;

  typedef struct packed {
    logic                         rgb_mode;
    frame_sel_t                   frame_select;
    logic signed [MIN_BITS-1:0]   display_min;
    logic signed [SCALE_BITS-1:0] stretch_scale;
    logic [GAIN_BITS-1:0]         gain_red;
    logic [GAIN_BITS-1:0]         gain_green;
    logic [GAIN_BITS-1:0]         gain_blue;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_red;
    logic signed [SAMPLE_BITS-1:0] sample_green;
    logic signed [SAMPLE_BITS-1:0] sample_blue;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level_red;
    logic [LEVEL_BITS-1:0] level_green;
    logic [LEVEL_BITS-1:0] level_blue;
  } out_word_t;

  typedef struct packed {
    logic ld_bal;
    logic ld_diff;
    logic ld_prod;
    logic ld_level;
  } stage_ld_t;

endpackage

// ----- rtl/dsrgb_cfg.sv -----
// Configuration register file for the display stretch and RGB balance block.
// Depends on dsrgb_pkg.
module dsrgb_cfg
  import dsrgb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rgb_mode      <= 1'b0;
      cfg.frame_select  <= SEL_ALL;
      cfg.display_min   <= '0;
      cfg.stretch_scale <= SCALE_BITS'(1 << 16);
      cfg.gain_red      <= GAIN_UNITY;
      cfg.gain_green    <= GAIN_UNITY;
      cfg.gain_blue     <= GAIN_UNITY;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RGB_MODE:      cfg.rgb_mode      <= cfg_data[0];
        REG_FRAME_SELECT:  cfg.frame_select  <= frame_sel_t'(cfg_data[1:0]);
        REG_DISPLAY_MIN:   cfg.display_min   <= cfg_data[MIN_BITS-1:0];
        REG_STRETCH_SCALE: cfg.stretch_scale <= cfg_data[SCALE_BITS-1:0];
        REG_GAIN_RED:      cfg.gain_red      <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_GREEN:    cfg.gain_green    <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_BLUE:     cfg.gain_blue     <= cfg_data[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/dsrgb_lane.sv -----
// One color lane: balance multiply, offset and saturate, split stretch multiply, clamp.
// Depends on dsrgb_pkg; load strobes come from the top-level pipeline control.
module dsrgb_lane
  import dsrgb_pkg::*;
(
  input  logic                          clk,
  input  stage_ld_t                     ld,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [GAIN_BITS-1:0]          gain,
  input  logic signed [MIN_BITS-1:0]    display_min,
  input  logic signed [SCALE_BITS-1:0]  stretch_scale,
  output logic [LEVEL_BITS-1:0]         level
);

  localparam logic signed [WIDE_BITS-1:0] DIFF_POS = WIDE_BITS'(1) << DIFF_EXP;
  localparam logic signed [WIDE_BITS-1:0] DIFF_NEG = -DIFF_POS;

  logic signed [BAL_BITS-1:0]  bal;
  logic signed [SAT_BITS-1:0]  diff_sat;
  logic signed [PL_BITS-1:0]   prod_lo;
  logic signed [PH_BITS-1:0]   prod_hi;
  logic                        diff_neg;

  logic signed [WIDE_BITS-1:0] bal_w;
  logic signed [WIDE_BITS-1:0] min_w;
  logic signed [WIDE_BITS-1:0] diff;
  logic signed [WIDE_BITS-1:0] diff_clip;
  logic signed [PROD_BITS-1:0] prod;

  always_comb begin
    bal_w = WIDE_BITS'(bal);
    min_w = WIDE_BITS'(display_min) <<< GAIN_FRAC;
    diff  = bal_w - min_w;
    priority if (diff > DIFF_POS) begin
      diff_clip = DIFF_POS;
    end else if (diff < DIFF_NEG) begin
      diff_clip = DIFF_NEG;
    end else begin
      diff_clip = diff;
    end
  end

  assign prod = (PROD_BITS'(prod_hi) <<< LO_BITS) + PROD_BITS'(prod_lo);

  always_ff @(posedge clk) begin
    if (ld.ld_bal) begin
      bal <= BAL_BITS'($signed({1'b0, gain})) * BAL_BITS'(sample);
    end
    if (ld.ld_diff) begin
      diff_sat <= diff_clip[SAT_BITS-1:0];
    end
    if (ld.ld_prod) begin
      prod_lo  <= PL_BITS'($signed({1'b0, diff_sat[LO_BITS-1:0]})) *
                  PL_BITS'(stretch_scale);
      prod_hi  <= PH_BITS'($signed(diff_sat[SAT_BITS-1:LO_BITS])) *
                  PH_BITS'(stretch_scale);
      diff_neg <= diff_sat[SAT_BITS-1];
    end
    if (ld.ld_level) begin
      priority if (stretch_scale == '0) begin
        level <= diff_neg ? LEVEL_MIN : LEVEL_MAX;
      end else if (prod[PROD_BITS-1]) begin
        level <= LEVEL_MIN;
      end else if (|prod[PROD_BITS-2:PROD_FRAC+LEVEL_BITS]) begin
        level <= LEVEL_MAX;
      end else begin
        level <= prod[PROD_FRAC+LEVEL_BITS-1:PROD_FRAC];
      end
    end
  end

endmodule

// ----- rtl/display_stretch_rgb_balance.sv -----
// Display stretch with RGB balance: four register stages (balance multiply, offset and
// saturate, split stretch multiply, clamp into the output register).
// Throughput one word per cycle; a stall holds every stage that has no free slot after it.
// Synchronous active-high reset clears the stage valid bits and loads the register defaults.
// Depends on dsrgb_pkg, dsrgb_cfg and dsrgb_lane.
module display_stretch_rgb_balance
  import dsrgb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_write,
  input  logic [INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data
);

  localparam int STAGES = 4;

  cfg_t                    cfg;
  logic [STAGES-1:0]       valid;
  logic [STAGES-1:0]       ce;
  stage_ld_t               ld;
  logic                    sel_red;
  logic                    sel_green;
  logic                    sel_blue;
  logic signed [SAMPLE_BITS-1:0] lane_sample [3];
  logic [GAIN_BITS-1:0]          lane_gain   [3];
  logic [LEVEL_BITS-1:0]         lane_level  [3];

  dsrgb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_comb begin
    ce[STAGES-1] = !valid[STAGES-1] || !out_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      ce[k] = !valid[k] || ce[k+1];
    end
  end

  assign in_stall    = !ce[0];
  assign out_valid   = valid[STAGES-1];
  assign ld.ld_bal   = ce[0];
  assign ld.ld_diff  = ce[1];
  assign ld.ld_prod  = ce[2];
  assign ld.ld_level = ce[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ce[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (ce[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign sel_red   = (cfg.frame_select == SEL_ALL) || (cfg.frame_select == SEL_RED);
  assign sel_green = (cfg.frame_select == SEL_ALL) || (cfg.frame_select == SEL_GREEN);
  assign sel_blue  = (cfg.frame_select == SEL_ALL) || (cfg.frame_select == SEL_BLUE);

  always_comb begin
    if (cfg.rgb_mode) begin
      lane_sample[0] = in_word.sample_red;
      lane_sample[1] = in_word.sample_green;
      lane_sample[2] = in_word.sample_blue;
      lane_gain[0]   = sel_red   ? cfg.gain_red   : '0;
      lane_gain[1]   = sel_green ? cfg.gain_green : '0;
      lane_gain[2]   = sel_blue  ? cfg.gain_blue  : '0;
    end else begin
      lane_sample[0] = in_word.sample_red;
      lane_sample[1] = in_word.sample_red;
      lane_sample[2] = in_word.sample_red;
      lane_gain[0]   = GAIN_UNITY;
      lane_gain[1]   = GAIN_UNITY;
      lane_gain[2]   = GAIN_UNITY;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    dsrgb_lane u_lane (
      .clk           (clk),
      .ld            (ld),
      .sample        (lane_sample[c]),
      .gain          (lane_gain[c]),
      .display_min   (cfg.display_min),
      .stretch_scale (cfg.stretch_scale),
      .level         (lane_level[c])
    );
  end

  assign out_word.level_red   = lane_level[0];
  assign out_word.level_green = lane_level[1];
  assign out_word.level_blue  = lane_level[2];

`ifndef SYNTHESIS
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&valid) && out_stall)
    else $error("input stalled while the pipeline has a free slot");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word valid right after reset");

  a_mono_gray: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cfg.rgb_mode |->
      (out_word.level_red == out_word.level_green) &&
      (out_word.level_red == out_word.level_blue))
    else $error("mono word with unequal channel levels");

  a_threshold: assert property (@(posedge clk) disable iff (rst)
    out_valid && (cfg.stretch_scale == '0) |->
      ((out_word.level_red == LEVEL_MIN) || (out_word.level_red == LEVEL_MAX)) &&
      ((out_word.level_green == LEVEL_MIN) || (out_word.level_green == LEVEL_MAX)) &&
      ((out_word.level_blue == LEVEL_MIN) || (out_word.level_blue == LEVEL_MAX)))
    else $error("threshold mode gave an intermediate level");
`endif

endmodule
